### hw/rtl/tgr_pkg.sv
// ============================================================================
// Text glyph row renderer package
// Shared constants for the bitmap-font text renderer: font store geometry,
// request and register codes, and register reset values.
// ============================================================================
`default_nettype none

package tgr_pkg;

    // Font store geometry
    localparam int GLYPH_COUNT = 256;
    localparam int ROW_SLOTS   = 16;
    localparam int STORE_DEPTH = GLYPH_COUNT * ROW_SLOTS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ROW_AW      = $clog2(ROW_SLOTS);

    // Field widths fixed by the interface
    localparam int CHR_W   = 8;
    localparam int COORD_W = 12;
    localparam int COLOR_W = 24;
    localparam int CFG_W   = 5;
    localparam int COL_W   = 9;
    localparam int LINE_W  = 8;

    // Character that starts a new line
    localparam logic [CHR_W-1:0] NEWLINE_CODE = 8'd10;

    // Request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    // Configuration register indexes
    localparam logic CFG_FONT_HEIGHT = 1'b0;
    localparam logic CFG_LINE_PITCH  = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] FONT_HEIGHT_RST = 5'd16;
    localparam logic [CFG_W-1:0] LINE_PITCH_RST  = 5'd9;

endpackage : tgr_pkg

`default_nettype wire

### hw/rtl/text_glyph_row_renderer_unit.sv
// ============================================================================
// Text glyph row renderer
// Bitmap-font text renderer: load requests fill a font store one glyph row
// byte at a time, draw requests emit the glyph rows of one character, with an
// optional drop shadow, at the current text column and line of a string.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ------------------------------------
//  in       sink       in_valid / in_stall  req_type, font_addr, font_byte,
//                                           char_code, string_start, origin_x,
//                                           origin_y, fore_color, shade_color,
//                                           shadow_on
//  out      source     out_valid/out_stall  pixel_x, pixel_y, row_bits,
//                                           row_color, last_row
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  A load request or a newline never leaves the idle state, so in_stall stays low.
//  A drawn character holds the block from the accept through the ST_BASE and
//  ST_PHASE setup states and then ST_EMIT, which emits rows * (1 + shadow_on)
//  rows, up to 32. The first row follows the ST_BASE and ST_PHASE states.
//  The row rate is set by the single read port of the font store, which
//  delivers one row per cycle through its registered read data when not stalled.
//  Reset clears the sequencer, column, line and registers; the font store
//  is not cleared and holds unknown data until written.
//  An output stall holds the current row and freezes the row sequencer.
//
`default_nettype none

module text_glyph_row_renderer_unit
    import tgr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // Request channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               req_type,
    input  wire logic [11:0]        font_addr,
    input  wire logic [7:0]         font_byte,
    input  wire logic [CHR_W-1:0]   char_code,
    input  wire logic               string_start,
    input  wire logic [COORD_W-1:0] origin_x,
    input  wire logic [COORD_W-1:0] origin_y,
    input  wire logic [COLOR_W-1:0] fore_color,
    input  wire logic [COLOR_W-1:0] shade_color,
    input  wire logic               shadow_on,

    // Result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [COORD_W-1:0]      pixel_x,
    output logic [COORD_W-1:0]      pixel_y,
    output logic [7:0]              row_bits,
    output logic [COLOR_W-1:0]      row_color,
    output logic                    last_row,

    // Configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_PHASE,
        ST_EMIT
    } state_t;

    // Sequencer and counters
    state_t               state_reg, state_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic [ROW_AW-1:0]    row_reg, row_next;
    logic [ROW_AW-1:0]    last_reg, last_next;
    logic                 shade_phase_reg, shade_phase_next;
    logic [CFG_W-1:0]     font_height_reg, font_height_next;
    logic [CFG_W-1:0]     line_pitch_reg, line_pitch_next;

    // Captured request payload and coordinates
    logic [CHR_W-1:0]     chr_reg, chr_next;
    logic [COORD_W-1:0]   org_x_reg, org_x_next;
    logic [COORD_W-1:0]   org_y_reg, org_y_next;
    logic [COLOR_W-1:0]   fore_reg, fore_next;
    logic [COLOR_W-1:0]   shade_reg, shade_next;
    logic                 shadow_reg, shadow_next;
    logic [COORD_W-1:0]   base_x_reg, base_x_next;
    logic [COORD_W-1:0]   base_y_reg, base_y_next;
    logic [COORD_W-1:0]   x_reg, x_next;
    logic [COORD_W-1:0]   y_reg, y_next;

    // Font store and its read path
    logic [7:0]           glyph_mem [STORE_DEPTH];
    logic [7:0]           rd_data_reg;
    logic [ROW_AW-1:0]    rd_row;
    logic [STORE_AW-1:0]  rd_addr;
    logic                 chr_ok;

    // Handshake terms and helper values
    logic                 in_fire;
    logic                 out_fire;
    logic                 load_wr;
    logic [CFG_W-1:0]     rows_clamped;
    logic [LINE_W+CFG_W-1:0] line_offset;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid && !out_stall;
    assign load_wr   = in_fire && (req_type == REQ_LOAD)
                       && ({1'b0, font_addr} < 13'(STORE_DEPTH));

    // Rows per character, forced into the range one to ROW_SLOTS.
    always_comb
    begin
        if (font_height_reg == '0)
        begin
            rows_clamped = CFG_W'(1);
        end
        else if (font_height_reg > CFG_W'(ROW_SLOTS))
        begin
            rows_clamped = CFG_W'(ROW_SLOTS);
        end
        else
        begin
            rows_clamped = font_height_reg;
        end
    end

    assign line_offset = line_reg * line_pitch_reg;

    // Read row: look one row ahead when the current row leaves, so the
    // registered read data always matches the row shown on the outputs.
    always_comb
    begin
        if (out_fire)
        begin
            rd_row = (row_reg == last_reg) ? '0 : row_reg + ROW_AW'(1);
        end
        else
        begin
            rd_row = row_reg;
        end
    end

    assign rd_addr = STORE_AW'({chr_reg, rd_row});
    assign chr_ok  = ({1'b0, chr_reg} < (CHR_W + 1)'(GLYPH_COUNT));

    // Font store: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            glyph_mem[font_addr[STORE_AW-1:0]] <= font_byte;
        end
        rd_data_reg <= glyph_mem[rd_addr];
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next       = state_reg;
        col_next         = col_reg;
        line_next        = line_reg;
        row_next         = row_reg;
        last_next        = last_reg;
        shade_phase_next = shade_phase_reg;
        font_height_next = font_height_reg;
        line_pitch_next  = line_pitch_reg;
        chr_next         = chr_reg;
        org_x_next       = org_x_reg;
        org_y_next       = org_y_reg;
        fore_next        = fore_reg;
        shade_next       = shade_reg;
        shadow_next      = shadow_reg;
        base_x_next      = base_x_reg;
        base_y_next      = base_y_reg;
        x_next           = x_reg;
        y_next           = y_reg;

        // The user must write registers only while the block is idle; the block itself does not enforce this.
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FONT_HEIGHT)
            begin
                font_height_next = cfg_data;
            end
            else
            begin
                line_pitch_next = cfg_data;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (req_type == REQ_DRAW))
                begin
                    chr_next   = char_code;
                    org_x_next = origin_x;
                    org_y_next = origin_y;
                    fore_next  = fore_color;
                    shade_next = shade_color;
                    shadow_next = shadow_on;
                    row_next   = '0;
                    if (string_start)
                    begin
                        col_next  = '0;
                        line_next = '0;
                    end
                    if (char_code == NEWLINE_CODE)
                    begin
                        col_next  = '0;
                        line_next = (string_start ? '0 : line_reg) + LINE_W'(1);
                    end
                    else
                    begin
                        state_next = ST_BASE;
                    end
                end
            end

            // Character origin from column and line, then advance the column.
            ST_BASE:
            begin
                base_x_next = org_x_reg + {col_reg, 3'b000};
                base_y_next = org_y_reg + line_offset[COORD_W-1:0];
                last_next   = ROW_AW'(rows_clamped - CFG_W'(1));
                col_next    = col_reg + COL_W'(1);
                state_next  = ST_PHASE;
            end

            // First pass starts at the shadow offset when the shadow is on.
            ST_PHASE:
            begin
                x_next           = base_x_reg + COORD_W'(shadow_reg);
                y_next           = base_y_reg + COORD_W'(shadow_reg);
                shade_phase_next = shadow_reg;
                state_next       = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_fire)
                begin
                    if (row_reg != last_reg)
                    begin
                        row_next = row_reg + ROW_AW'(1);
                        y_next   = y_reg + COORD_W'(1);
                    end
                    else if (shade_phase_reg)
                    begin
                        // Shadow pass done: restart at the glyph origin.
                        row_next         = '0;
                        x_next           = base_x_reg;
                        y_next           = base_y_reg;
                        shade_phase_next = 1'b0;
                    end
                    else
                    begin
                        row_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state, counters, captured payload and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            col_reg         <= '0;
            line_reg        <= '0;
            row_reg         <= '0;
            last_reg        <= '0;
            shade_phase_reg <= 1'b0;
            font_height_reg <= FONT_HEIGHT_RST;
            line_pitch_reg  <= LINE_PITCH_RST;
            chr_reg         <= '0;
            org_x_reg       <= '0;
            org_y_reg       <= '0;
            fore_reg        <= '0;
            shade_reg       <= '0;
            shadow_reg      <= 1'b0;
            base_x_reg      <= '0;
            base_y_reg      <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            col_reg         <= col_next;
            line_reg        <= line_next;
            row_reg         <= row_next;
            last_reg        <= last_next;
            shade_phase_reg <= shade_phase_next;
            font_height_reg <= font_height_next;
            line_pitch_reg  <= line_pitch_next;
            chr_reg         <= chr_next;
            org_x_reg       <= org_x_next;
            org_y_reg       <= org_y_next;
            fore_reg        <= fore_next;
            shade_reg       <= shade_next;
            shadow_reg      <= shadow_next;
            base_x_reg      <= base_x_next;
            base_y_reg      <= base_y_next;
            x_reg           <= x_next;
            y_reg           <= y_next;
        end
    end

    // Result fields
    assign pixel_x   = x_reg;
    assign pixel_y   = y_reg;
    assign row_bits  = chr_ok ? rd_data_reg : 8'h00;
    assign row_color = shade_phase_reg ? shade_reg : fore_reg;
    assign last_row  = !shade_phase_reg && (row_reg == last_reg);

`ifndef SYNTH
    // A result is never shown while a new request could be taken.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("result shown while request channel is open");

    // A drawn printable character always leads to the busy sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (req_type == REQ_DRAW) && (char_code != NEWLINE_CODE))
        |=> in_stall)
        else $error("draw request did not start the row sequence");

    // Load requests complete in the cycle they are taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (req_type == REQ_LOAD)) |=> !in_stall)
        else $error("load request kept the block busy");

    // The row counter never runs past the character's last row.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_reg <= last_reg))
        else $error("row counter beyond last row");

    // The final row of a character ends the result sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_row) |=> !out_valid)
        else $error("results continued after the last row");
`endif

endmodule : text_glyph_row_renderer_unit

`default_nettype wire
